[rtl/upd_pkg.sv]
package upd_pkg;

	localparam int Window = 3;
	localparam int EchoW = 15;
	localparam int ThrW = 9;
	localparam int HoldW = 16;
	localparam int DistW = 18;
	localparam int ScaleW = 11;
	localparam int DistShift = 8;
	localparam int ProdW = EchoW + ScaleW;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	localparam logic [ScaleW-1:0] DistScale = 11'd1124;
	localparam logic [HoldW-1:0] ElapsedMax = 16'hFFFF;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] RegMinEcho = 2'd0;
	localparam logic [CfgIdxW-1:0] RegMaxEcho = 2'd1;
	localparam logic [CfgIdxW-1:0] RegThreshold = 2'd2;
	localparam logic [CfgIdxW-1:0] RegHold = 2'd3;

	localparam logic [EchoW-1:0] MinEchoReset = 15'd117;
	localparam logic [EchoW-1:0] MaxEchoReset = 15'd23323;
	localparam logic [ThrW-1:0] ThresholdReset = 9'd100;
	localparam logic [HoldW-1:0] HoldReset = 16'd5000;

	// window filter status toward the presence logic
	typedef struct packed {
		logic done;
		logic valid;
		logic [EchoW-1:0] median;
	} win_res_t;

	// one result item
	typedef struct packed {
		logic [DistW-1:0] dist_q8;
		logic valid;
		logic present;
		logic changed;
	} pres_res_t;

endpackage

[rtl/upd_window.sv]
module upd_window (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [upd_pkg::EchoW-1:0] width,
	input logic got,
	input logic [upd_pkg::EchoW-1:0] min_echo,
	input logic [upd_pkg::EchoW-1:0] max_echo,
	output upd_pkg::win_res_t res
);
	import upd_pkg::*;

	logic [EchoW-1:0] samp_q [Window];
	logic [1:0] pos_q;
	logic [1:0] acc_q;
	logic [1:0] acc_nx;
	logic take;
	logic [EchoW-1:0] samp_nx [Window];

	function automatic logic [EchoW-1:0] max2(input logic [EchoW-1:0] a,
		input logic [EchoW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [EchoW-1:0] min2(input logic [EchoW-1:0] a,
		input logic [EchoW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	assign take = got && (width >= min_echo) && (width <= max_echo);
	assign acc_nx = acc_q + {1'b0, take};

	always_comb begin
		for (int i = 0; i < Window; i++) begin
			samp_nx[i] = (take && (acc_q == 2'(i))) ? width : samp_q[i];
		end
	end

	always_comb begin
		res.done = (pos_q == 2'(Window - 1));
		res.valid = (acc_nx != 2'd0);
		case (acc_nx)
			2'd1: res.median = samp_nx[0];
			2'd2: res.median = max2(samp_nx[0], samp_nx[1]);
			2'd3: res.median = max2(min2(samp_nx[0], samp_nx[1]),
				min2(max2(samp_nx[0], samp_nx[1]), samp_nx[2]));
			default: res.median = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
		end else if (en) begin
			if (res.done) begin
				pos_q <= '0;
				acc_q <= '0;
			end else begin
				pos_q <= pos_q + 2'd1;
				acc_q <= acc_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			samp_q[acc_q] <= width;
		end
	end

	a_acc_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= pos_q) else $error("accepted count exceeds window position");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 2'(Window)) else $error("window position past window end");

endmodule

[rtl/upd_presence.sv]
module upd_presence (
	input logic clk,
	input logic arst_n,
	input logic tick_en,
	input logic meas_en,
	input upd_pkg::win_res_t win,
	input logic [upd_pkg::ThrW-1:0] threshold,
	input logic [upd_pkg::HoldW-1:0] hold,
	output upd_pkg::pres_res_t res
);
	import upd_pkg::*;

	logic [HoldW-1:0] elapsed_q;
	logic seen_q;
	logic flag_q;
	logic [ProdW-1:0] prod;
	logic detected;

	assign prod = ProdW'(win.median) * ProdW'(DistScale);

	always_comb begin
		res.valid = win.valid;
		res.dist_q8 = win.valid ? prod[DistShift +: DistW] : '0;
		detected = win.valid && (res.dist_q8 <= {1'b0, threshold, 8'h00});
		res.present = detected || (seen_q && (elapsed_q < hold));
		res.changed = res.present != flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			seen_q <= 1'b0;
			flag_q <= 1'b0;
		end else if (tick_en) begin
			if (elapsed_q != ElapsedMax) begin
				elapsed_q <= elapsed_q + 16'd1;
			end
		end else if (meas_en) begin
			if (detected) begin
				elapsed_q <= '0;
				seen_q <= 1'b1;
			end
			flag_q <= res.present;
		end
	end

endmodule

[rtl/ultrasonic_presence_detector_top.sv]
// A window-closing measurement passes the input stage register, then the output register.
// One item per cycle unless stalled; ticks and window-filling measurements produce no result.
// The input stage stalls only while a finished result waits at the output and the
// item in the input stage would produce another one.
// Reset (arst_n low, asynchronous): window empty, hold timer zero, presence off,
// configuration at its defaults; sample storage keeps no reset value.
module ultrasonic_presence_detector_top (
	input logic clk,
	input logic arst_n,
	// input channel
	input logic in_valid,
	output logic in_stall,
	input logic op,
	input logic [upd_pkg::EchoW-1:0] echo_width_us,
	input logic got_echo,
	// result channel
	output logic out_valid,
	input logic out_stall,
	output logic [upd_pkg::DistW-1:0] distance_q8,
	output logic distance_valid,
	output logic present,
	output logic changed,
	// configuration write port
	input logic cfg_we,
	input logic [upd_pkg::CfgIdxW-1:0] cfg_index,
	input logic [upd_pkg::CfgDataW-1:0] cfg_data
);
	import upd_pkg::*;

	// configuration registers
	logic [EchoW-1:0] min_echo_q;
	logic [EchoW-1:0] max_echo_q;
	logic [ThrW-1:0] threshold_q;
	logic [HoldW-1:0] hold_q;

	// input stage
	logic valid_s1;
	logic op_s1;
	logic [EchoW-1:0] width_s1;
	logic got_s1;

	// output stage
	logic out_valid_q;
	pres_res_t out_q;

	logic in_xfer;
	logic advance;
	logic emits;
	win_res_t win;
	pres_res_t pres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_echo_q <= MinEchoReset;
			max_echo_q <= MaxEchoReset;
			threshold_q <= ThresholdReset;
			hold_q <= HoldReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMinEcho: min_echo_q <= cfg_data[EchoW-1:0];
				RegMaxEcho: max_echo_q <= cfg_data[EchoW-1:0];
				RegThreshold: threshold_q <= cfg_data[ThrW-1:0];
				RegHold: hold_q <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	// A measurement that closes the window produces a result; it may only
	// leave the input stage when the output register is free or draining.
	assign emits = valid_s1 && op_s1 && win.done;
	assign advance = valid_s1 && (!emits || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold payload while stalled, load on every transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1 <= op;
			width_s1 <= echo_width_us;
			got_s1 <= got_echo;
		end
	end

	upd_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance && op_s1),
		.width(width_s1),
		.got(got_s1),
		.min_echo(min_echo_q),
		.max_echo(max_echo_q),
		.res(win)
	);

	upd_presence u_presence (
		.clk(clk),
		.arst_n(arst_n),
		.tick_en(advance && !op_s1),
		.meas_en(advance && emits),
		.win(win),
		.threshold(threshold_q),
		.hold(hold_q),
		.res(pres)
	);

	// output register: load a new result, drop the old one once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emits) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emits) begin
			out_q <= pres;
		end
	end

	assign out_valid = out_valid_q;
	assign distance_q8 = out_q.dist_q8;
	assign distance_valid = out_q.valid;
	assign present = out_q.present;
	assign changed = out_q.changed;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && emits))
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emits) |=> out_valid_q)
		else $error("closed window did not reach the output");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.valid) |-> (out_q.dist_q8 == '0))
		else $error("invalid window carries a distance");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import upd_pkg::*;

	// item kinds on the op field
	localparam logic OpTick = 1'b0;
	localparam logic OpMeasure = 1'b1;

	localparam int EchoMax = 30000;       // top of the echo width range
	localparam int ThrMax = 400;
	localparam int IdleLimit = 4000;      // cycles with no transfer on either side
	localparam int DrainCycles = 8;       // settle time after the last expected result, with margin
	localparam int ReportMax = 40;        // print at most this many mismatch lines
	localparam int RandomPhases = 7;
	localparam int ItemsPerPhase = 107;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OpTick;
	logic [EchoW-1:0] echo_width_us = '0;
	logic got_echo = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [DistW-1:0] distance_q8;
	logic distance_valid;
	logic present;
	logic changed;

	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = RegMinEcho;
	logic [CfgDataW-1:0] cfg_data = '0;

	ultrasonic_presence_detector_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.echo_width_us  (echo_width_us),
		.got_echo       (got_echo),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.distance_q8    (distance_q8),
		.distance_valid (distance_valid),
		.present        (present),
		.changed        (changed),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the detector: register file plus window and hold-timer state,
	// starting from the reset values.
	logic [EchoW-1:0] cfg_min_echo = MinEchoReset;
	logic [EchoW-1:0] cfg_max_echo = MaxEchoReset;
	logic [ThrW-1:0] cfg_threshold = ThresholdReset;
	logic [HoldW-1:0] cfg_hold = HoldReset;

	logic [EchoW-1:0] window_widths [Window];
	int unsigned window_fill = 0;
	int unsigned window_kept = 0;
	logic [HoldW-1:0] ms_since_seen = '0;
	bit target_seen = 1'b0;
	bit presence_now = 1'b0;

	// expected result items, oldest first
	pres_res_t presence_results[$];

	// stimulus shaping knobs, switched per phase
	bit in_gaps_on = 1'b1;
	bit out_stalls_on = 1'b1;

	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned valid_windows = 0;
	int unsigned presence_flips = 0;
	int unsigned settings_used = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;

	// Mostly back-to-back, often a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Median of the widths kept in this window; with two, the larger one.
	function automatic logic [EchoW-1:0] window_median();
		logic [EchoW-1:0] a, b, c, lo, hi;
		a = window_widths[0];
		b = window_widths[1];
		c = window_widths[2];
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case (window_kept)
			1: return a;
			2: return hi;
			default: return (c < lo) ? lo : ((c > hi) ? hi : c);
		endcase
	endfunction

	// Advance the shadow detector by one transferred item and queue the result it
	// produces, if any.
	function automatic void advance_detector(logic kind, logic [EchoW-1:0] width,
			logic echo_seen);
		logic [31:0] dist_full;
		bit valid, hit, pres;
		pres_res_t res;
		dist_full = '0;
		if (kind == OpTick) begin
			// saturate the hold timer
			if (ms_since_seen != ElapsedMax)
				ms_since_seen++;
			return;
		end
		if (echo_seen && width >= cfg_min_echo && width <= cfg_max_echo &&
				window_kept < Window) begin
			window_widths[window_kept] = width;
			window_kept++;
		end
		window_fill++;
		if (window_fill < Window)
			return;
		valid = window_kept > 0;
		if (valid)
			dist_full = (32'(window_median()) * 32'(DistScale)) >> DistShift;
		window_fill = 0;
		window_kept = 0;
		hit = valid && dist_full <= (32'(cfg_threshold) << 8);
		if (hit) begin
			ms_since_seen = '0;
			target_seen = 1'b1;
		end
		pres = hit || (target_seen && ms_since_seen < cfg_hold);
		res.dist_q8 = dist_full[DistW-1:0];
		res.valid = valid;
		res.present = pres;
		res.changed = pres != presence_now;
		presence_now = pres;
		presence_results.push_back(res);
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= ReportMax)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// Compare one transferred result against the oldest expectation.
	task automatic check_result();
		pres_res_t exp_res;
		if (presence_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result dist=%0d valid=%0b present=%0b",
				distance_q8, distance_valid, present));
			return;
		end
		exp_res = presence_results.pop_front();
		results_checked++;
		if (exp_res.valid)
			valid_windows++;
		if (exp_res.changed)
			presence_flips++;
		if (distance_q8 !== exp_res.dist_q8)
			report_mismatch($sformatf("distance_q8 got %0d expected %0d",
				distance_q8, exp_res.dist_q8));
		if (distance_valid !== exp_res.valid)
			report_mismatch($sformatf("distance_valid got %0b expected %0b",
				distance_valid, exp_res.valid));
		if (present !== exp_res.present)
			report_mismatch($sformatf("present got %0b expected %0b",
				present, exp_res.present));
		if (changed !== exp_res.changed)
			report_mismatch($sformatf("changed got %0b expected %0b",
				changed, exp_res.changed));
	endtask

	// Result side: check every transfer, throttle with random stalls, and watch for
	// a hang. Inputs sampled here hold their values from before the edge.
	always @(posedge clk) begin
		int n;
		if (arst_n && out_valid && !out_stall)
			check_result();

		if (!out_stalls_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				stall_left = n - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end

		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
				$time, idle_cycles, presence_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one item after an optional pause and hold it until the transfer.
	// Called right after a rising edge; returns right after the transfer edge.
	task automatic send_item(logic kind, logic [EchoW-1:0] width, logic echo_seen);
		int gap;
		gap = in_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		echo_width_us <= width;
		got_echo <= echo_seen;
		do @(posedge clk); while (in_stall);
		advance_detector(kind, width, echo_seen);
		items_sent++;
	endtask

	task automatic send_measure(int unsigned width, bit echo_seen);
		send_item(OpMeasure, EchoW'(width), echo_seen);
	endtask

	task automatic send_tick();
		send_item(OpTick, EchoW'($urandom_range(0, EchoMax)), 1'($urandom_range(0, 1)));
	endtask

	// Drop valid, wait for every expected result, then let the pipeline settle so
	// that no window-filling measurement is still in flight.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (presence_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write all four registers back to back; only call while drained.
	task automatic set_config(int unsigned min_us, int unsigned max_us, int unsigned thr_cm,
			int unsigned hold);
		cfg_we <= 1'b1;
		cfg_index <= RegMinEcho;
		cfg_data <= CfgDataW'(min_us);
		@(posedge clk);
		cfg_index <= RegMaxEcho;
		cfg_data <= CfgDataW'(max_us);
		@(posedge clk);
		cfg_index <= RegThreshold;
		cfg_data <= CfgDataW'(thr_cm);
		@(posedge clk);
		cfg_index <= RegHold;
		cfg_data <= CfgDataW'(hold);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_min_echo = EchoW'(min_us);
		cfg_max_echo = EchoW'(max_us);
		cfg_threshold = ThrW'(thr_cm);
		cfg_hold = HoldW'(hold);
		settings_used++;
	endtask

	// Reset registers: limits at both edges, timeouts, invalid window, two kept widths.
	task automatic test_default_limits();
		send_measure(116, 1'b1);
		send_measure(117, 1'b1);
		send_measure(23323, 1'b1);
		send_measure(23324, 1'b1);
		send_measure(500, 1'b0);
		send_measure(0, 1'b1);
		send_measure(EchoMax, 1'b0);
		send_measure(5000, 1'b1);
		send_measure(2000, 1'b1);
		send_tick();
		send_tick();
		send_measure(3000, 1'b1);
		send_measure(1000, 1'b1);
		send_measure(2000, 1'b1);
	endtask

	// Widest limits, largest threshold, no hold: presence only while detected.
	task automatic test_zero_hold();
		drain_pipeline();
		set_config(0, EchoMax, ThrMax, 0);
		repeat (3) send_measure(0, 1'b1);
		send_tick();
		send_measure(EchoMax, 1'b0);
		send_measure(0, 1'b0);
		send_measure(12345, 1'b0);
		repeat (3) send_measure(EchoMax, 1'b1);
	endtask

	// Min above max rejects everything; then zero threshold with the smallest widths.
	task automatic test_crossed_limits();
		drain_pipeline();
		set_config(5000, 4000, 0, 16'hFFFF);
		send_measure(4500, 1'b1);
		send_measure(5000, 1'b1);
		send_measure(4000, 1'b1);
		drain_pipeline();
		set_config(0, EchoMax, 0, 3);
		send_measure(0, 1'b1);
		send_measure(1, 1'b1);
		send_measure(0, 1'b1);
	endtask

	// Short hold: one tick below the hold time still holds, at the hold time the
	// presence drops, and further ticks keep it off.
	task automatic test_hold_expiry();
		drain_pipeline();
		in_gaps_on = 1'b0;
		set_config(0, EchoMax, ThrMax, 5);
		repeat (3) send_measure(0, 1'b1);
		repeat (4) send_tick();
		repeat (3) send_measure($urandom_range(0, EchoMax), 1'b0);
		send_tick();
		repeat (3) send_measure($urandom_range(0, EchoMax), 1'b0);
		repeat (4) send_tick();
		repeat (3) send_measure($urandom_range(0, EchoMax), 1'b0);
		in_gaps_on = 1'b1;
	endtask

	// Pick a measurement width: mostly inside the limits or close to the distance
	// threshold, some on the limit edges, the rest anywhere in range.
	function automatic int unsigned pick_width();
		int unsigned lo, hi, center, sel;
		lo = (cfg_min_echo <= cfg_max_echo) ? cfg_min_echo : 0;
		hi = (cfg_min_echo <= cfg_max_echo) ? cfg_max_echo : EchoMax;
		if (hi > EchoMax)
			hi = EchoMax;
		if (lo > hi)
			lo = hi;
		center = cfg_threshold * 58;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $urandom_range(lo, hi);
		if (sel < 7)
			return $urandom_range((center > 300) ? center - 300 : 0,
				(center + 300 > EchoMax) ? EchoMax : center + 300);
		if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return (cfg_min_echo == 0) ? 0 : cfg_min_echo - 1;
				1: return (cfg_min_echo > EchoMax) ? EchoMax : cfg_min_echo;
				2: return (cfg_max_echo > EchoMax) ? EchoMax : cfg_max_echo;
				default: return (cfg_max_echo >= EchoMax) ? EchoMax : cfg_max_echo + 1;
			endcase
		end
		return $urandom_range(0, EchoMax);
	endfunction

	// Phases of random traffic, each under its own register setting and idling mix.
	task automatic test_random_traffic();
		int unsigned lo, hi, sent, burst;
		for (int phase = 0; phase < RandomPhases; phase++) begin
			drain_pipeline();
			case (phase)
				0: set_config($urandom_range(0, 500), $urandom_range(20000, EchoMax),
					$urandom_range(0, ThrMax), $urandom_range(0, 20));
				1: set_config(0, EchoMax, ThrMax, 0);
				2: set_config(EchoMax, EchoMax, 0, 16'hFFFF);
				3: begin
					// crossed limits under traffic
					hi = $urandom_range(0, EchoMax - 1);
					set_config($urandom_range(hi + 1, EchoMax), hi,
						$urandom_range(0, ThrMax), $urandom_range(0, 30));
				end
				default: begin
					lo = $urandom_range(0, EchoMax);
					set_config(lo, $urandom_range(lo, EchoMax), $urandom_range(0, ThrMax),
						$urandom_range(0, 40));
				end
			endcase
			in_gaps_on = (phase % 4) < 2;
			out_stalls_on = (phase % 4) != 1 && (phase % 4) != 3;
			sent = 0;
			while (sent < ItemsPerPhase) begin
				if ($urandom_range(0, 99) < 35) begin
					// a short burst of ticks ages the hold timer
					burst = $urandom_range(1, 4);
					repeat (burst) send_tick();
					sent += burst;
				end else begin
					send_measure(pick_width(), $urandom_range(0, 9) != 0);
					sent++;
				end
			end
		end
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
	endtask

	initial begin
		// hold reset, then release it on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limits();
		test_zero_hold();
		test_crossed_limits();
		test_hold_expiry();
		test_random_traffic();

		drain_pipeline();
		$display("Run covered %0d items and %0d results (%0d valid windows, %0d presence changes)",
			items_sent, results_checked, valid_windows, presence_flips);
		$display("under %0d register settings, including limit extremes and hold expiry",
			settings_used);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
